// ===== design/itcf_pkg.sv =====
// itcf_pkg: shared types and constants of the tilt filter
// no dependencies; used by every module of the block
package itcf_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_OFF_AX     = 3'd0,
    REG_OFF_AY     = 3'd1,
    REG_OFF_GX     = 3'd2,
    REG_OFF_GY     = 3'd3,
    REG_OFF_GZ     = 3'd4,
    REG_GYRO_SCALE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] off_ax;
    logic signed [15:0] off_ay;
    logic signed [15:0] off_gx;
    logic signed [15:0] off_gy;
    logic signed [15:0] off_gz;
    logic [15:0]        gyro_scale;
  } cfg_t;

  localparam int CORD_W  = 26;   // cordic x/y datapath
  localparam int Z_W     = 21;   // cordic angle accumulator, q16 radians
  localparam int DQ_W    = 40;   // dividend bits of the rate*dt divider
  localparam int DIV_K   = 125;  // 256000 = 2^11 * 125
  localparam int DIV_N   = 38;   // dividend of the divide by 125 stays below 2^38
  localparam int DIV_SH  = 45;   // DIV_N + 7
  // reciprocal of 125, ceil(2^45 / 125), exact for every dividend below 2^38
  localparam longint DIV_M = ((64'sd1 <<< 45) + 64'sd124) / 64'sd125;
  localparam int PI_Q16  = 205887;
  localparam int W_GYRO  = 64225;
  localparam int W_ACC   = 1311;
  localparam int ANG_MAX = 8388607;
  localparam int ANG_MIN = -8388608;
  localparam int DT_RND  = 128000;

  // arctangent of 2^-i in q16, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = Z_W'(51472);
      5'd1:    v = Z_W'(30386);
      5'd2:    v = Z_W'(16055);
      5'd3:    v = Z_W'(8150);
      5'd4:    v = Z_W'(4091);
      5'd5:    v = Z_W'(2047);
      5'd6:    v = Z_W'(1024);
      5'd7:    v = Z_W'(512);
      5'd8:    v = Z_W'(256);
      5'd9:    v = Z_W'(128);
      5'd10:   v = Z_W'(64);
      5'd11:   v = Z_W'(32);
      5'd12:   v = Z_W'(16);
      5'd13:   v = Z_W'(8);
      5'd14:   v = Z_W'(4);
      5'd15:   v = Z_W'(2);
      5'd16:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/imu_tilt_complementary_filter.sv =====
// imu_tilt_complementary_filter: top level of the tilt estimator
// depends on itcf_pkg, itcf_front, itcf_fifo, itcf_back
//
// usage
// - input channel (in_valid / in_stall): one raw six-axis sample per transfer;
//   in_elapsed_ms is taken from the last sample of each group
// - every SAMPLES_PER_OUTPUT samples the group is averaged, offset corrected
//   and both tilt angles updated; one result transfer on out_valid / out_stall
//   carries angle_x, angle_y (q7.16 rad, saturated) and the averaged z rate
// - non-final samples give no result, they are only summed
// - configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): offsets and
//   gyro scale, always ready; the user must write them only while the block
//   is idle, and the block itself does not enforce this
// - from the last sample of a group to out_valid: queue pop, reciprocal
//   average, cordic set-up, the cordic iterations, multiplies ST_MUL1 to
//   ST_MUL3, divide set-up, reciprocal divide by 125, ST_BLEND1, ST_BLEND2
//   and the result load; the back end takes one group at a time, which sets
//   the sustained rate
// - samples are taken at one a cycle while the two-entry group queue has room
// - a stalled result is held in the output register; the back end then waits
//   with its finished group, the queue fills and in_stall rises
// - synchronous reset clears sums, tilt state, registers and the queue
module imu_tilt_complementary_filter #(
  parameter int SAMPLES_PER_OUTPUT = 2,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_x,
  input  logic signed [15:0] in_gyro_y,
  input  logic signed [15:0] in_gyro_z,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_angle_x,
  output logic signed [23:0] out_angle_y,
  output logic signed [16:0] out_rate_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import itcf_pkg::*;

  // sums of up to SAMPLES_PER_OUTPUT 16-bit samples
  localparam int SUM_W = 16 + $clog2(SAMPLES_PER_OUTPUT);
  localparam int ENT_W = 6 * SUM_W + 16;

  cfg_t             cfg_r;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  logic [ENT_W-1:0] q_din;
  logic [ENT_W-1:0] q_dout;

  // always ready; each configuration write is registered into cfg_r
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OFF_AX:     cfg_r.off_ax     <= cfg_data;
        REG_OFF_AY:     cfg_r.off_ay     <= cfg_data;
        REG_OFF_GX:     cfg_r.off_gx     <= cfg_data;
        REG_OFF_GY:     cfg_r.off_gy     <= cfg_data;
        REG_OFF_GZ:     cfg_r.off_gz     <= cfg_data;
        REG_GYRO_SCALE: cfg_r.gyro_scale <= cfg_data;
        default:        cfg_r            <= cfg_r;  // unused indexes ignored
      endcase
    end
  end

  // front end: group summing
  itcf_front #(
    .SAMPLES_PER_OUTPUT (SAMPLES_PER_OUTPUT),
    .SUM_W              (SUM_W),
    .ENT_W              (ENT_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_gyro_x     (in_gyro_x),
    .in_gyro_y     (in_gyro_y),
    .in_gyro_z     (in_gyro_z),
    .in_elapsed_ms (in_elapsed_ms),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_din)
  );

  // queue of finished groups between the two halves
  itcf_fifo #(
    .W (ENT_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // back end: average, cordic, rate integration, blend, result register
  itcf_back #(
    .SAMPLES_PER_OUTPUT (SAMPLES_PER_OUTPUT),
    .CORDIC_STEPS       (CORDIC_STEPS),
    .SUM_W              (SUM_W),
    .ENT_W              (ENT_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_dout),
    .q_pop       (q_pop),
    .cfg         (cfg_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_angle_x (out_angle_x),
    .out_angle_y (out_angle_y),
    .out_rate_z  (out_rate_z)
  );

endmodule

// ===== design/itcf_front.sv =====
// itcf_front: sums raw samples over a group and hands the group to the queue
// depends on itcf_pkg
module itcf_front #(
  parameter int SAMPLES_PER_OUTPUT = 2,
  parameter int SUM_W = 17,
  parameter int ENT_W = 6 * 17 + 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       in_accel_x,
  input  logic signed [15:0]       in_accel_y,
  input  logic signed [15:0]       in_accel_z,
  input  logic signed [15:0]       in_gyro_x,
  input  logic signed [15:0]       in_gyro_y,
  input  logic signed [15:0]       in_gyro_z,
  input  logic [15:0]              in_elapsed_ms,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [ENT_W-1:0]         q_data
);
  import itcf_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_OUTPUT + 1);

  logic signed [SUM_W-1:0] sum_r [6];
  logic signed [SUM_W-1:0] sum_nxt [6];
  logic signed [15:0]      smp [6];
  logic [CNT_W-1:0]        cnt_r;
  logic                    take;
  logic                    last;

  assign smp[0] = in_accel_x;
  assign smp[1] = in_accel_y;
  assign smp[2] = in_accel_z;
  assign smp[3] = in_gyro_x;
  assign smp[4] = in_gyro_y;
  assign smp[5] = in_gyro_z;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;
  assign last     = (cnt_r == CNT_W'(SAMPLES_PER_OUTPUT - 1));
  assign q_push   = take && last;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sum_nxt[k] = sum_r[k] + SUM_W'(smp[k]);
    end
  end

  // entry layout: elapsed_ms above six sums, accel x in the low bits
  always_comb begin
    q_data = '0;
    for (int k = 0; k < 6; k++) begin
      q_data[k*SUM_W +: SUM_W] = sum_nxt[k];
    end
    q_data[6*SUM_W +: 16] = in_elapsed_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int k = 0; k < 6; k++) sum_r[k] <= '0;
    end else if (take) begin
      if (last) begin
        cnt_r <= '0;
        for (int k = 0; k < 6; k++) sum_r[k] <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
        for (int k = 0; k < 6; k++) sum_r[k] <= sum_nxt[k];
      end
    end
  end

endmodule

// ===== design/itcf_fifo.sv =====
// itcf_fifo: two-entry queue of finished sample groups
// depends on itcf_pkg
module itcf_fifo #(
  parameter int W = 118
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import itcf_pkg::*;

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/itcf_back.sv =====
// itcf_back: averages a group, runs two cordic lanes, rate*dt and the blend
// depends on itcf_pkg; fed from itcf_fifo
module itcf_back #(
  parameter int SAMPLES_PER_OUTPUT = 2,
  parameter int CORDIC_STEPS = 16,
  parameter int SUM_W = 17,
  parameter int ENT_W = 6 * 17 + 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  logic [ENT_W-1:0]         q_data,
  output logic                     q_pop,
  input  itcf_pkg::cfg_t           cfg,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [23:0]       out_angle_x,
  output logic signed [23:0]       out_angle_y,
  output logic signed [16:0]       out_rate_z
);
  import itcf_pkg::*;

  localparam int RW = $clog2(SAMPLES_PER_OUTPUT) + 1;
  // offset sums stay below 2^AVG_N; reciprocal of the group size
  localparam int AVG_N  = RW + 15;
  localparam int AVG_SH = AVG_N + RW - 1;
  localparam int AVG_M  = ((1 << AVG_SH) + SAMPLES_PER_OUTPUT - 1) / SAMPLES_PER_OUTPUT;
  localparam logic [19:0] DM_LO = 20'(DIV_M);
  localparam logic [18:0] DM_HI = 19'(DIV_M >> 20);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_AVG    = 12'b000000000010,
    ST_CINIT  = 12'b000000000100,
    ST_CORD   = 12'b000000001000,
    ST_MUL1   = 12'b000000010000,
    ST_MUL2   = 12'b000000100000,
    ST_MUL3   = 12'b000001000000,
    ST_DPREP  = 12'b000010000000,
    ST_DDIV   = 12'b000100000000,
    ST_BLEND1 = 12'b001000000000,
    ST_BLEND2 = 12'b010000000000,
    ST_DONE   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0] cnt_r;

  logic [AVG_N-1:0]          u_r [6];
  logic [15:0]               aq_r [6];
  logic [15:0]               ms_r;
  logic signed [CORD_W-1:0]  cx_r [2];
  logic signed [CORD_W-1:0]  cy_r [2];
  logic signed [Z_W-1:0]     cz_r [2];
  logic                      hold_r [2];
  logic signed [16:0]        rate_r [2];
  logic signed [16:0]        gz_r;
  logic signed [33:0]        pr_r [2];
  logic signed [42:0]        plo_r [2];
  logic signed [42:0]        phi_r [2];
  logic [DQ_W-1:0]           dq_r [2];
  logic [57:0]               dlo_r [2];
  logic [57:0]               dhi_r [2];
  logic                      dneg_r [2];
  logic signed [52:0]        m1_r [2];
  logic signed [32:0]        m2_r [2];
  logic signed [23:0]        tilt_r [2];
  logic                      out_valid_r;
  logic signed [23:0]        out_ax_r;
  logic signed [23:0]        out_ay_r;
  logic signed [16:0]        out_rz_r;

  logic                      out_free;

  assign out_valid   = out_valid_r;
  assign out_angle_x = out_ax_r;
  assign out_angle_y = out_ay_r;
  assign out_rate_z  = out_rz_r;
  assign out_free    = !out_valid_r || !out_stall;
  assign q_pop       = (state_r == ST_IDLE) && !q_empty;

  // average: floor(sum / n) found as (sum + n*32768) / n - 32768,
  // the divide as a multiply by the rounded-up reciprocal of n
  logic [AVG_N-1:0]        u_init [6];
  logic signed [SUM_W+1:0] u_full [6];
  logic [2*AVG_N:0]        uq [6];
  logic signed [15:0]      avg [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      u_full[k] = (SUM_W+2)'($signed(q_data[k*SUM_W +: SUM_W]))
                + (SUM_W+2)'(SAMPLES_PER_OUTPUT * 32768);
      u_init[k] = u_full[k][AVG_N-1:0];
      uq[k]     = (2*AVG_N+1)'(u_r[k]) * (2*AVG_N+1)'(AVG_M);
      avg[k]    = $signed({~aq_r[k][15], aq_r[k][14:0]});
    end
  end

  // offset correction; accel z stays raw
  logic signed [16:0] ax, ay, gx, gy, gz;
  assign ax = 17'(avg[0]) - 17'(cfg.off_ax);
  assign ay = 17'(avg[1]) - 17'(cfg.off_ay);
  assign gx = 17'(avg[3]) - 17'(cfg.off_gx);
  assign gy = 17'(avg[4]) - 17'(cfg.off_gy);
  assign gz = 17'(avg[5]) - 17'(cfg.off_gz);

  // cordic set-up, lane 0 gives the x tilt, lane 1 the y tilt
  logic signed [16:0]       cy_in [2];
  logic signed [17:0]       xa [2];
  logic signed [17:0]       ya [2];
  logic signed [Z_W-1:0]    z0 [2];
  logic                     xneg;
  logic                     yz [2];

  assign cy_in[0] = ay;
  assign cy_in[1] = ax;
  assign xneg     = avg[2][15];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      yz[l] = (cy_in[l] == 17'sd0);
      xa[l] = xneg ? -18'(avg[2]) : 18'(avg[2]);
      ya[l] = xneg ? -18'(cy_in[l]) : 18'(cy_in[l]);
      if (yz[l]) begin
        z0[l] = xneg ? Z_W'(PI_Q16) : '0;
      end else if (xneg) begin
        z0[l] = cy_in[l][16] ? -Z_W'(PI_Q16) : Z_W'(PI_Q16);
      end else begin
        z0[l] = '0;
      end
    end
  end

  // one micro-rotation per cycle
  logic [4:0]               sh;
  logic signed [CORD_W-1:0] xs [2];
  logic signed [CORD_W-1:0] ys [2];
  logic signed [Z_W-1:0]    at_i;

  assign sh   = cnt_r[4:0];
  assign at_i = atan_q16(sh);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xs[l] = cx_r[l] >>> sh;
      ys[l] = cy_r[l] >>> sh;
    end
  end

  // rate*dt: round_half_up(p / 256000) via shift then divide by 125,
  // the divide as a reciprocal multiply split into low and high partial products
  logic signed [51:0] p [2];
  logic signed [51:0] pn [2];
  logic signed [51:0] pm [2];
  logic [77:0]        dsum [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p[l]    = 52'(plo_r[l]) + (52'(phi_r[l]) <<< 8) + 52'(DT_RND);
      pn[l]   = p[l] >>> 11;
      pm[l]   = p[l][51] ? (-pn[l] + 52'(DIV_K - 1)) : pn[l];
      dsum[l] = 78'(dlo_r[l]) + (78'(dhi_r[l]) << 20);
    end
  end

  // blend
  logic signed [33:0] delta [2];
  logic signed [34:0] s [2];
  logic signed [53:0] tot [2];
  logic signed [53:0] r [2];
  logic signed [23:0] rsat [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      delta[l] = dneg_r[l] ? -$signed({2'b00, dq_r[l][31:0]})
                           : $signed({2'b00, dq_r[l][31:0]});
      s[l]     = 35'(tilt_r[l]) + 35'(delta[l]);
      tot[l]   = 54'(m1_r[l]) + 54'(m2_r[l]) + 54'(32768);
      r[l]     = tot[l] >>> 16;
      if (r[l] > 54'(ANG_MAX)) begin
        rsat[l] = 24'(ANG_MAX);
      end else if (r[l] < 54'(ANG_MIN)) begin
        rsat[l] = 24'(ANG_MIN);
      end else begin
        rsat[l] = r[l][23:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (!q_empty) state_nxt = ST_AVG;
      ST_AVG:    state_nxt = ST_CINIT;
      ST_CINIT:  state_nxt = ST_CORD;
      ST_CORD:   if (cnt_r == 6'(CORDIC_STEPS - 1)) state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_MUL3;
      ST_MUL3:   state_nxt = ST_DPREP;
      ST_DPREP:  state_nxt = ST_DDIV;
      ST_DDIV:   if (cnt_r == 6'd2) state_nxt = ST_BLEND1;
      ST_BLEND1: state_nxt = ST_BLEND2;
      ST_BLEND2: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      tilt_r[0]   <= '0;
      tilt_r[1]   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (!q_empty) begin
            ms_r <= q_data[6*SUM_W +: 16];
            for (int k = 0; k < 6; k++) u_r[k] <= u_init[k];
          end
        end
        ST_AVG: begin
          cnt_r <= '0;
          for (int k = 0; k < 6; k++) aq_r[k] <= uq[k][AVG_SH +: 16];
        end
        ST_CINIT: begin
          cnt_r     <= '0;
          rate_r[0] <= gx;
          rate_r[1] <= gy;
          gz_r      <= gz;
          for (int l = 0; l < 2; l++) begin
            cx_r[l]   <= CORD_W'(xa[l]) <<< 6;
            cy_r[l]   <= CORD_W'(ya[l]) <<< 6;
            cz_r[l]   <= z0[l];
            hold_r[l] <= yz[l];
          end
        end
        ST_CORD: begin
          cnt_r <= (cnt_r == 6'(CORDIC_STEPS - 1)) ? '0 : cnt_r + 1'b1;
          for (int l = 0; l < 2; l++) begin
            if (!hold_r[l]) begin
              if (!cy_r[l][CORD_W-1]) begin
                cx_r[l] <= cx_r[l] + ys[l];
                cy_r[l] <= cy_r[l] - xs[l];
                cz_r[l] <= cz_r[l] + at_i;
              end else begin
                cx_r[l] <= cx_r[l] - ys[l];
                cy_r[l] <= cy_r[l] + xs[l];
                cz_r[l] <= cz_r[l] - at_i;
              end
            end
          end
        end
        ST_MUL1: begin
          for (int l = 0; l < 2; l++) begin
            pr_r[l] <= rate_r[l] * $signed({1'b0, cfg.gyro_scale});
          end
        end
        ST_MUL2: begin
          for (int l = 0; l < 2; l++) begin
            plo_r[l] <= pr_r[l] * $signed({1'b0, ms_r[7:0]});
          end
        end
        ST_MUL3: begin
          for (int l = 0; l < 2; l++) begin
            phi_r[l] <= pr_r[l] * $signed({1'b0, ms_r[15:8]});
          end
        end
        ST_DPREP: begin
          cnt_r <= '0;
          for (int l = 0; l < 2; l++) begin
            dq_r[l]   <= pm[l][DQ_W-1:0];
            dneg_r[l] <= p[l][51];
          end
        end
        ST_DDIV: begin
          cnt_r <= (cnt_r == 6'd2) ? '0 : cnt_r + 1'b1;
          for (int l = 0; l < 2; l++) begin
            if (cnt_r == 6'd0) begin
              dlo_r[l] <= 58'(dq_r[l][DIV_N-1:0]) * 58'(DM_LO);
            end else if (cnt_r == 6'd1) begin
              dhi_r[l] <= 58'(dq_r[l][DIV_N-1:0]) * 58'(DM_HI);
            end else begin
              dq_r[l] <= DQ_W'(dsum[l] >> DIV_SH);
            end
          end
        end
        ST_BLEND1: begin
          for (int l = 0; l < 2; l++) begin
            m1_r[l] <= s[l] * $signed(18'(W_GYRO));
            m2_r[l] <= cz_r[l] * $signed(12'(W_ACC));
          end
        end
        ST_BLEND2: begin
          tilt_r[0] <= rsat[0];
          tilt_r[1] <= rsat[1];
        end
        ST_DONE: begin
          if (out_free) begin
            out_ax_r <= tilt_r[0];
            out_ay_r <= tilt_r[1];
            out_rz_r <= gz_r;
          end
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  // a held result keeps its value until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_ax_r) && $stable(out_ay_r)))
    else $error("result changed while stalled");

  // cordic iteration count stays inside its range
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORD) |-> (cnt_r < 6'(CORDIC_STEPS)))
    else $error("cordic step counter out of range");

  // queue is popped only when the back end is free
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_AVG))
    else $error("pop without starting a group");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

// ===== test/testbench.sv =====
// testbench for imu_tilt_complementary_filter: sample driver, result monitor and
// a bit-exact predictor of the grouped complementary filter; depends on itcf_pkg
`timescale 1ns / 1ps

module testbench;
  import itcf_pkg::*;

  localparam int GROUP = 2;      // samples per result, matches the dut default
  localparam int STEPS = 16;     // cordic iterations, matches the dut default
  localparam int PHASE_ITEMS = 270;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
    logic [15:0]        ms;
  } sample_t;

  typedef struct {
    logic signed [23:0] ang_x, ang_y;
    logic signed [16:0] rz;
  } tilt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [15:0] in_gyro_x = '0, in_gyro_y = '0, in_gyro_z = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_angle_x, out_angle_y;
  logic signed [16:0] out_rate_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  imu_tilt_complementary_filter dut (.*);

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // predictor copy of the block's registers and state
  longint off_ax, off_ay, off_gx, off_gy, off_gz, scale;
  longint acc_ax, acc_ay, acc_az, acc_gx, acc_gy, acc_gz;
  int     group_fill;
  longint tilt_x, tilt_y;

  sample_t pending_q[$];     // samples waiting for the driver
  tilt_t   tilt_q[$];        // predicted results, oldest first
  sample_t cur;              // sample currently on the input ports
  int      gap_left;
  int      stall_left;
  int      long_hold;
  logic    hold_start = 1'b0;
  bit      steady;           // no random idling on either side
  int      errors;

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d != 0) && ((a < 0) != (d < 0))) q -= 1;
    return q;
  endfunction

  // fixed-iteration cordic arctangent, q16 radians
  function automatic longint atan2_q16(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (y == 0) return (x < 0) ? PI_Q16 : 0;
    if (x < 0) begin
      z = (y > 0) ? PI_Q16 : -PI_Q16;
      x = -x;
      y = -y;
    end
    x *= 64;
    y *= 64;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_q16(5'(i));
      end else begin
        x -= ys; y += xs; z -= atan_q16(5'(i));
      end
    end
    return z;
  endfunction

  // gyro integration then weighted blend with the accel angle, saturated
  function automatic longint blend(longint ang, longint rate, longint ms, longint acc);
    longint s, r;
    s = ang + fdiv(rate * scale * ms + DT_RND, 256000);
    r = fdiv(s * W_GYRO + acc * W_ACC + 32768, 65536);
    if (r > ANG_MAX) r = ANG_MAX;
    if (r < ANG_MIN) r = ANG_MIN;
    return r;
  endfunction

  // sums one accepted sample; at the end of a group pushes the expected result
  task automatic accumulate_sample(sample_t s);
    longint ax, ay, az, gx, gy, gz;
    tilt_t t;
    acc_ax += s.ax; acc_ay += s.ay; acc_az += s.az;
    acc_gx += s.gx; acc_gy += s.gy; acc_gz += s.gz;
    group_fill++;
    if (group_fill < GROUP) return;
    ax = fdiv(acc_ax, GROUP) - off_ax;
    ay = fdiv(acc_ay, GROUP) - off_ay;
    az = fdiv(acc_az, GROUP);
    gx = fdiv(acc_gx, GROUP) - off_gx;
    gy = fdiv(acc_gy, GROUP) - off_gy;
    gz = fdiv(acc_gz, GROUP) - off_gz;
    tilt_x = blend(tilt_x, gx, s.ms, atan2_q16(ay, az));
    tilt_y = blend(tilt_y, gy, s.ms, atan2_q16(ax, az));
    t.ang_x = 24'(tilt_x);
    t.ang_y = 24'(tilt_y);
    t.rz = 17'(gz);
    tilt_q.push_back(t);
    acc_ax = 0; acc_ay = 0; acc_az = 0; acc_gx = 0; acc_gy = 0; acc_gz = 0;
    group_fill = 0;
  endtask

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 16);
  endfunction

  // input driver: one transfer per accepted sample, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) accumulate_sample(cur);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          in_accel_x <= cur.ax; in_accel_y <= cur.ay; in_accel_z <= cur.az;
          in_gyro_x <= cur.gx; in_gyro_y <= cur.gy; in_gyro_z <= cur.gz;
          in_elapsed_ms <= cur.ms;
          in_valid <= 1'b1;
          gap_left = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here on its own
  always @(posedge clk) begin
    if (hold_start) long_hold <= 600;
    else if (long_hold > 0) long_hold <= long_hold - 1;
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    tilt_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tilt_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result with nothing expected: %0d %0d %0d",
                     out_angle_x, out_angle_y, out_rate_z);
        end else begin
          e = tilt_q.pop_front();
          if (out_angle_x !== e.ang_x || out_angle_y !== e.ang_y || out_rate_z !== e.rz) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       e.ang_x, e.ang_y, e.rz, out_angle_x, out_angle_y, out_rate_z);
          end
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) stall_left--;
      out_stall <= (stall_left > 0) || (long_hold > 1) || hold_start;
    end
  end

  // one register transfer; predictor copy updated when it is taken
  task automatic cfg_write(cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OFF_AX:     off_ax = longint'($signed(val));
      REG_OFF_AY:     off_ay = longint'($signed(val));
      REG_OFF_GX:     off_gx = longint'($signed(val));
      REG_OFF_GY:     off_gy = longint'($signed(val));
      REG_OFF_GZ:     off_gz = longint'($signed(val));
      REG_GYRO_SCALE: scale = longint'(val);
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [15:0] ax, ay, gx, gy, gz, sc);
    cfg_write(REG_OFF_AX, ax);
    cfg_write(REG_OFF_AY, ay);
    cfg_write(REG_OFF_GX, gx);
    cfg_write(REG_OFF_GY, gy);
    cfg_write(REG_OFF_GZ, gz);
    cfg_write(REG_GYRO_SCALE, sc);
  endtask

  function automatic sample_t mk(int ax, ay, az, gx, gy, gz, ms);
    sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    s.ms = 16'(ms);
    return s;
  endfunction

  // mostly plausible sensor readings, some full range, some with zero numerators
  function automatic sample_t rand_sample();
    sample_t s;
    int kind;
    kind = $urandom_range(0, 9);
    s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
    s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
    s.ms = 16'($urandom);
    if (kind >= 3) begin
      s.ax = 16'($urandom_range(0, 8000) - 4000);
      s.ay = 16'($urandom_range(0, 8000) - 4000);
      s.az = 16'($urandom_range(0, 36000) - 18000);
      s.gx = 16'($urandom_range(0, 2000) - 1000);
      s.gy = 16'($urandom_range(0, 2000) - 1000);
      s.ms = 16'($urandom_range(0, 40));
    end
    if (kind == 8) begin
      s.ax = '0;
      s.ay = '0;
    end
    return s;
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (pending_q.size() > 0 || in_valid || tilt_q.size() > 0);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    group_fill = 0;
    long_hold = 0;
    steady = 1'b0;
    off_ax = 0; off_ay = 0; off_gx = 0; off_gy = 0; off_gz = 0; scale = 0;
    acc_ax = 0; acc_ay = 0; acc_az = 0; acc_gx = 0; acc_gy = 0; acc_gz = 0;
    tilt_x = 0; tilt_y = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both-zero and zero-numerator atan2, negative accel z
    cfg_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000);
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 10));
    pending_q.push_back(mk(0, 0, -1000, 0, 0, 5, 0));
    pending_q.push_back(mk(0, 0, -1000, 0, 0, 5, 1));
    pending_q.push_back(mk(500, 700, -2000, 0, 0, 0, 0));
    pending_q.push_back(mk(500, 700, -2000, 0, 0, 0, 5));
    pending_q.push_back(mk(-500, -700, -2000, 0, 0, 0, 0));
    pending_q.push_back(mk(-500, -700, -2000, 0, 0, 0, 5));
    pending_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 65535));
    pending_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 65535));
    pending_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0));
    pending_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
    pending_q.push_back(mk(32767, -32768, 0, -32768, 32767, 0, 65535));
    pending_q.push_back(mk(32767, -32768, 1, -32768, 32767, 1, 65535));
    pending_q.push_back(mk(1, -1, 16384, 1, -1, -1, 1));
    pending_q.push_back(mk(0, -1, 16384, 1, -1, -1, 1));
    pending_q.push_back(mk(-1, 1, -1, 0, 0, 0, 0));
    pending_q.push_back(mk(-1, 1, 0, 0, 0, 0, 2));
    wait_drained();

    // random phases across register settings, extremes among them
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: cfg_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: cfg_all(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        2: cfg_all(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        default: cfg_all(16'($urandom_range(0, 600) - 300), 16'($urandom_range(0, 600) - 300),
                         16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 200) - 100),
                         16'($urandom), 16'($urandom));
      endcase
      steady = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) pending_q.push_back(rand_sample());
      // fill the block while the result side holds off
      if (p == 3) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_drained();
    end

    if (errors == 0 && tilt_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
